// ----- rtl/polar_scan_to_cartesian_defines.svh -----
// assertion macros for the polar scan to cartesian converter
// no dependencies; included by the files that carry assertions
`ifndef POLAR_SCAN_TO_CARTESIAN_DEFINES_SVH
`define POLAR_SCAN_TO_CARTESIAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PST_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PST_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PST_ASSERT(label, clk, rstn, prop, msg)
`define PST_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define PST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/pst_pkg.sv -----
// constants, widths and the arctangent table of the polar to cartesian converter
// no dependencies
`timescale 1ns / 1ps

package pst_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int INDEX_CAP  = ((MAX_POINTS > 4096) ? 4096 : MAX_POINTS) - 1;

    localparam int RANGE_W  = 17;
    localparam int INTEN_W  = 16;
    localparam int COORD_W  = 22;
    localparam int INDEX_W  = 12;
    localparam int START_W  = 20;
    localparam int STEP_W   = 19;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 20;

    localparam int ANGLE_W  = 33;   // start + index * step, signed
    localparam int APROD_W  = INDEX_W + STEP_W;
    localparam int TURN_W   = 19;   // reduced angle below one turn
    localparam int QUART_W  = 17;   // angle inside one quadrant
    localparam int VEC_W    = 32;   // cordic vector, q30
    localparam int ZANG_W   = 23;   // residual angle, 1/16 mdeg
    localparam int ATAN_W   = 20;
    localparam int PROD_W   = RANGE_W + VEC_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_SH  = 26;   // 30 bit fraction less the 4 bit 1/16 mm scale
    localparam int SCALED_W = SUM_W - FRAC_SH;
    localparam int STEP_CNT_W = 5;

    localparam int TURN_MDEG    = 360000;
    localparam int QUARTER_MDEG = 90000;
    localparam int REDUCE_TOP   = 13;   // 360000 << 13 is above any angle sum
    localparam int CORDIC_ITERS = 18;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int COORD_LIMIT  = 1048576;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BEAM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = CFG_IDX_W'(1);

    // arctan(2^-i) in 1/16 millidegree, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_CNT_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = ATAN_W'(720000);
            5'd1:    v = ATAN_W'(425041);
            5'd2:    v = ATAN_W'(224580);
            5'd3:    v = ATAN_W'(114000);
            5'd4:    v = ATAN_W'(57221);
            5'd5:    v = ATAN_W'(28639);
            5'd6:    v = ATAN_W'(14323);
            5'd7:    v = ATAN_W'(7162);
            5'd8:    v = ATAN_W'(3581);
            5'd9:    v = ATAN_W'(1790);
            5'd10:   v = ATAN_W'(895);
            5'd11:   v = ATAN_W'(448);
            5'd12:   v = ATAN_W'(224);
            5'd13:   v = ATAN_W'(112);
            5'd14:   v = ATAN_W'(56);
            5'd15:   v = ATAN_W'(28);
            5'd16:   v = ATAN_W'(14);
            5'd17:   v = ATAN_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/polar_scan_to_cartesian.sv -----
// polar lidar sample to cartesian point converter, top level
// depends on pst_pkg and polar_scan_to_cartesian_defines.svh
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_range_mm, s_intensity, s_scan_start
//  m_        out        m_valid / m_ready    m_x_pos, m_y_pos, m_point_intensity,
//                                            m_point_index
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a valid sample passes one angle multiply, one wrap, 14 compare/subtract steps of the
// modulo-turn reduction, one quadrant split, 18 shared cordic iterations, one fold,
// the x and y products on the shared range multiplier and a load of the output
// register before the next sample is accepted
// a sample with range zero or below is taken without leaving idle and gives no word
// synchronous active-low reset; cfg_ready is always high
// a stalled output word holds in the output register; the next sample is still
// accepted and computed, and waits in the last step until the register frees
`timescale 1ns / 1ps
`include "polar_scan_to_cartesian_defines.svh"

module polar_scan_to_cartesian (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pst_pkg::RANGE_W-1:0]   s_range_mm,
    input  logic        [pst_pkg::INTEN_W-1:0]   s_intensity,
    input  logic                                 s_scan_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pst_pkg::COORD_W-1:0]   m_x_pos,
    output logic signed [pst_pkg::COORD_W-1:0]   m_y_pos,
    output logic        [pst_pkg::INTEN_W-1:0]   m_point_intensity,
    output logic        [pst_pkg::INDEX_W-1:0]   m_point_index,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [pst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [pst_pkg::CFG_DAT_W-1:0] cfg_data
);
    import pst_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ANGLE  = 4'd1;
    localparam logic [3:0] ST_WRAP   = 4'd2;
    localparam logic [3:0] ST_REDUCE = 4'd3;
    localparam logic [3:0] ST_QUAD   = 4'd4;
    localparam logic [3:0] ST_ROTATE = 4'd5;
    localparam logic [3:0] ST_FOLD   = 4'd6;
    localparam logic [3:0] ST_MUL_X  = 4'd7;
    localparam logic [3:0] ST_MUL_Y  = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    logic [3:0]                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]       step_reg, step_next;
    logic [INDEX_W-1:0]          sample_index_reg, sample_index_next;
    logic signed [START_W-1:0]   first_beam_reg, first_beam_next;
    logic [STEP_W-1:0]           angle_step_reg, angle_step_next;

    logic signed [RANGE_W-1:0]   range_reg, range_next;
    logic [INTEN_W-1:0]          inten_reg, inten_next;
    logic [INDEX_W-1:0]          idx_reg, idx_next;
    logic signed [ANGLE_W-1:0]   angle_reg, angle_next;
    logic [1:0]                  quad_reg, quad_next;
    logic signed [VEC_W-1:0]     x_reg, x_next;
    logic signed [VEC_W-1:0]     y_reg, y_next;
    logic signed [ZANG_W-1:0]    z_reg, z_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [COORD_W-1:0]   x_res_reg, x_res_next;

    logic                        m_valid_reg, m_valid_next;
    logic signed [COORD_W-1:0]   m_x_pos_reg, m_x_pos_next;
    logic signed [COORD_W-1:0]   m_y_pos_reg, m_y_pos_next;
    logic [INTEN_W-1:0]          m_inten_reg, m_inten_next;
    logic [INDEX_W-1:0]          m_index_reg, m_index_next;

    logic                        in_accept;
    logic                        out_free;
    logic [INDEX_W-1:0]          idx_now;
    logic [APROD_W-1:0]          angle_prod;
    logic signed [ANGLE_W-1:0]   turn_mult;
    logic [TURN_W-1:0]           angle_low;
    logic [1:0]                  quad_calc;
    logic [QUART_W-1:0]          quart_angle;
    logic signed [VEC_W-1:0]     dx, dy;
    logic signed [ZANG_W-1:0]    atan_val;
    logic signed [PROD_W-1:0]    mult_in;
    logic signed [COORD_W-1:0]   scaled;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_x_pos           = m_x_pos_reg;
    assign m_y_pos           = m_y_pos_reg;
    assign m_point_intensity = m_inten_reg;
    assign m_point_index     = m_index_reg;

    assign idx_now    = s_scan_start ? '0 : sample_index_reg;
    assign angle_prod = APROD_W'(idx_reg) * APROD_W'(angle_step_reg);
    assign turn_mult  = ANGLE_W'(TURN_MDEG) << step_reg[3:0];
    assign angle_low  = angle_reg[TURN_W-1:0];

    // quadrant split of the reduced angle
    always_comb begin
        if (angle_low >= TURN_W'(3 * QUARTER_MDEG)) begin
            quad_calc   = 2'd3;
            quart_angle = QUART_W'(angle_low - TURN_W'(3 * QUARTER_MDEG));
        end else if (angle_low >= TURN_W'(2 * QUARTER_MDEG)) begin
            quad_calc   = 2'd2;
            quart_angle = QUART_W'(angle_low - TURN_W'(2 * QUARTER_MDEG));
        end else if (angle_low >= TURN_W'(QUARTER_MDEG)) begin
            quad_calc   = 2'd1;
            quart_angle = QUART_W'(angle_low - TURN_W'(QUARTER_MDEG));
        end else begin
            quad_calc   = 2'd0;
            quart_angle = QUART_W'(angle_low);
        end
    end

    // shared cordic shifter, floor shifts
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = $signed(ZANG_W'(atan_entry(step_reg)));

    // shared range multiplier and rounding with saturation
    assign mult_in = (state_reg == ST_MUL_X) ? PROD_W'(x_reg) : PROD_W'(y_reg);

    always_comb begin
        logic signed [SUM_W-1:0]    rsum;
        logic signed [SCALED_W-1:0] rshift;
        rsum   = SUM_W'(prod_reg) + SUM_W'(1 << (FRAC_SH - 1));
        rshift = SCALED_W'(rsum >>> FRAC_SH);
        if (rshift > SCALED_W'(COORD_LIMIT)) begin
            scaled = COORD_W'(COORD_LIMIT);
        end else if (rshift < -SCALED_W'(COORD_LIMIT)) begin
            scaled = -COORD_W'(COORD_LIMIT);
        end else begin
            scaled = rshift[COORD_W-1:0];
        end
    end

    always_comb begin
        state_next        = state_reg;
        step_next         = step_reg;
        sample_index_next = sample_index_reg;
        first_beam_next   = first_beam_reg;
        angle_step_next   = angle_step_reg;
        range_next        = range_reg;
        inten_next        = inten_reg;
        idx_next          = idx_reg;
        angle_next        = angle_reg;
        quad_next         = quad_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        prod_next         = prod_reg;
        x_res_next        = x_res_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_x_pos_next      = m_x_pos_reg;
        m_y_pos_next      = m_y_pos_reg;
        m_inten_next      = m_inten_reg;
        m_index_next      = m_index_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FIRST_BEAM: first_beam_next = $signed(cfg_data[START_W-1:0]);
                REG_ANGLE_STEP: angle_step_next = cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    range_next = s_range_mm;
                    inten_next = s_intensity;
                    idx_next   = idx_now;
                    if (idx_now < INDEX_W'(INDEX_CAP)) begin
                        sample_index_next = idx_now + INDEX_W'(1);
                    end else begin
                        sample_index_next = INDEX_W'(INDEX_CAP);
                    end
                    // invalid range: only the index moves
                    if (s_range_mm > 0) begin
                        state_next = ST_ANGLE;
                    end
                end
            end
            ST_ANGLE: begin
                angle_next = ANGLE_W'(first_beam_reg) + $signed(ANGLE_W'(angle_prod));
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                // sum never drops below -2^19, one double turn makes it positive
                if (angle_reg < 0) begin
                    angle_next = angle_reg + ANGLE_W'(2 * TURN_MDEG);
                end
                step_next  = STEP_CNT_W'(REDUCE_TOP);
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                if (angle_reg >= turn_mult) begin
                    angle_next = angle_reg - turn_mult;
                end
                step_next = step_reg - STEP_CNT_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_QUAD;
                end
            end
            ST_QUAD: begin
                quad_next  = quad_calc;
                x_next     = VEC_W'(CORDIC_GAIN);
                y_next     = '0;
                z_next     = $signed(ZANG_W'({quart_angle, 4'b0000}));
                step_next  = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (!z_reg[ZANG_W-1]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_val;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_val;
                end
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(CORDIC_ITERS - 1)) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                case (quad_reg)
                    2'd1: begin
                        x_next = -y_reg;
                        y_next = x_reg;
                    end
                    2'd2: begin
                        x_next = -x_reg;
                        y_next = -y_reg;
                    end
                    2'd3: begin
                        x_next = y_reg;
                        y_next = -x_reg;
                    end
                    default: ;
                endcase
                state_next = ST_MUL_X;
            end
            ST_MUL_X: begin
                prod_next  = PROD_W'(range_reg) * mult_in;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                x_res_next = scaled;
                prod_next  = PROD_W'(range_reg) * mult_in;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_x_pos_next = x_res_reg;
                    m_y_pos_next = scaled;
                    m_inten_next = inten_reg;
                    m_index_next = idx_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            sample_index_reg <= '0;
            first_beam_reg   <= '0;
            angle_step_reg   <= STEP_W'(1000);
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            sample_index_reg <= sample_index_next;
            first_beam_reg   <= first_beam_next;
            angle_step_reg   <= angle_step_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        range_reg   <= range_next;
        inten_reg   <= inten_next;
        idx_reg     <= idx_next;
        angle_reg   <= angle_next;
        quad_reg    <= quad_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        prod_reg    <= prod_next;
        x_res_reg   <= x_res_next;
        m_x_pos_reg <= m_x_pos_next;
        m_y_pos_reg <= m_y_pos_next;
        m_inten_reg <= m_inten_next;
        m_index_reg <= m_index_next;
    end

    `PST_ASSERT_NEXT(a_invalid_skips, aclk, aresetn, in_accept && (s_range_mm <= 0),
        s_ready, "invalid range started a conversion")
    `PST_ASSERT_NEXT(a_scan_restart, aclk, aresetn, in_accept && s_scan_start,
        sample_index_reg == INDEX_W'(1), "scan start did not restart the index")
    `PST_ASSERT_NEXT(a_rotate_len, aclk, aresetn,
        (state_reg == ST_ROTATE) && (step_reg == STEP_CNT_W'(CORDIC_ITERS - 1)),
        state_reg == ST_FOLD, "cordic did not stop after the last iteration")
    `PST_ASSERT(a_index_cap, aclk, aresetn, sample_index_reg <= INDEX_W'(INDEX_CAP),
        "sample index above its cap")
    `PST_ASSERT_SAME(a_coord_limit, aclk, aresetn, m_valid_reg,
        (m_x_pos_reg <= COORD_W'(COORD_LIMIT)) && (m_x_pos_reg >= -COORD_W'(COORD_LIMIT))
        && (m_y_pos_reg <= COORD_W'(COORD_LIMIT)) && (m_y_pos_reg >= -COORD_W'(COORD_LIMIT)),
        "output word outside coordinate limit")

endmodule

// ----- tb/polar_scan_to_cartesian_test.sv -----
// self-checking testbench for polar_scan_to_cartesian: lidar samples in, cartesian points out
// predicts every point with its own cordic model and checks each output word in order
// depends on pst_pkg and the polar_scan_to_cartesian rtl
`timescale 1ns / 1ps

module polar_scan_to_cartesian_test;
    import pst_pkg::*;

    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_ITEMS     = 160;
    localparam int LONG_SCAN_ITEMS = 400;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [INTEN_W-1:0] inten;
        logic        [INDEX_W-1:0] idx;
    } point_t;

    logic                         aclk;
    logic                         aresetn           = 1'b0;
    logic                         s_valid           = 1'b0;
    logic                         s_ready;
    logic signed [RANGE_W-1:0]    s_range_mm        = '0;
    logic        [INTEN_W-1:0]    s_intensity       = '0;
    logic                         s_scan_start      = 1'b0;
    logic                         m_valid;
    logic                         m_ready           = 1'b0;
    logic signed [COORD_W-1:0]    m_x_pos;
    logic signed [COORD_W-1:0]    m_y_pos;
    logic        [INTEN_W-1:0]    m_point_intensity;
    logic        [INDEX_W-1:0]    m_point_index;
    logic                         cfg_valid         = 1'b0;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic        [CFG_DAT_W-1:0]  cfg_data          = '0;

    // converter state as predicted
    longint             start_mdeg  = 0;
    longint             step_mdeg   = 1000;
    logic [INDEX_W-1:0] next_index  = '0;
    point_t             expected_points[$];

    longint atan_16th_mdeg [CORDIC_ITERS] = '{
        720000, 425041, 224580, 114000, 57221, 28639, 14323, 7162, 3581,
        1790, 895, 448, 224, 112, 56, 28, 14, 7
    };

    int mismatch_count = 0;
    int idle_cycles    = 0;
    bit sender_gaps    = 1'b1;
    bit sink_stalls    = 1'b1;
    bit hold_pending   = 1'b0;

    polar_scan_to_cartesian uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_range_mm        (s_range_mm),
        .s_intensity       (s_intensity),
        .s_scan_start      (s_scan_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_x_pos           (m_x_pos),
        .m_y_pos           (m_y_pos),
        .m_point_intensity (m_point_intensity),
        .m_point_index     (m_point_index),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // range times a q30 unit vector component, rounded to 1/16 mm and clamped
    function automatic logic signed [COORD_W-1:0] to_sixteenth_mm(input longint rng,
                                                                  input longint unit_q30);
        longint p;
        p = (rng * 16 * unit_q30 + (longint'(1) << 29)) >>> 30;
        if (p > COORD_LIMIT)
            p = COORD_LIMIT;
        else if (p < -COORD_LIMIT)
            p = -COORD_LIMIT;
        return COORD_W'(p);
    endfunction

    // register writes and accepted samples update the predicted state
    always @(posedge aclk) begin : sample_predictor
        logic [INDEX_W-1:0] idx;
        longint ang, zang, cx, cy, dx, dy, tmp;
        int quad;
        point_t pt;
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FIRST_BEAM: start_mdeg = longint'($signed(cfg_data));
                REG_ANGLE_STEP: step_mdeg  = longint'(cfg_data[STEP_W-1:0]);
                default: ;
            endcase
        end
        if (aresetn && s_valid && s_ready) begin
            if (s_scan_start)
                next_index = '0;
            idx = next_index;
            next_index = (idx < INDEX_CAP) ? idx + INDEX_W'(1) : INDEX_W'(INDEX_CAP);
            if (s_range_mm > 0) begin
                ang = start_mdeg + longint'(idx) * step_mdeg;
                ang = ang % TURN_MDEG;
                if (ang < 0)
                    ang += TURN_MDEG;
                quad = int'(ang / QUARTER_MDEG);
                zang = (ang - quad * QUARTER_MDEG) * 16;
                cx = CORDIC_GAIN;
                cy = 0;
                for (int i = 0; i < CORDIC_ITERS; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (zang >= 0) begin
                        cx -= dx;
                        cy += dy;
                        zang -= atan_16th_mdeg[i];
                    end else begin
                        cx += dx;
                        cy -= dy;
                        zang += atan_16th_mdeg[i];
                    end
                end
                case (quad)
                    1: begin
                        tmp = cx; cx = -cy; cy = tmp;
                    end
                    2: begin
                        cx = -cx; cy = -cy;
                    end
                    3: begin
                        tmp = cx; cx = cy; cy = -tmp;
                    end
                    default: ;
                endcase
                pt.x     = to_sixteenth_mm(longint'(s_range_mm), cx);
                pt.y     = to_sixteenth_mm(longint'(s_range_mm), cy);
                pt.inten = s_intensity;
                pt.idx   = idx;
                expected_points.insert(expected_points.size(), pt);
            end
        end
    end

    always @(posedge aclk) begin : point_checker
        point_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_x_pos, m_y_pos, m_point_intensity, m_point_index};
            if (expected_points.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected point x=%0d y=%0d inten=%0d idx=%0d", $time,
                         got.x, got.y, got.inten, got.idx);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: point mismatch expected x=%0d y=%0d inten=%0d idx=%0d",
                             $time, want.x, want.y, want.inten, want.idx);
                    $display("%0t:                actual x=%0d y=%0d inten=%0d idx=%0d",
                             $time, got.x, got.y, got.inten, got.idx);
                end
            end
        end
    end

    // output side: random stalls, or one long hold when asked
    initial begin : point_sink
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= !(sink_stalls && $urandom_range(0, 99) < 10);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("polar_scan_to_cartesian_test: FAIL");
            $finish;
        end
    end

    // valid stays up between back-to-back samples; it only drops for a gap
    task send_sample(input logic signed [RANGE_W-1:0] rng, input logic [INTEN_W-1:0] inten,
                     input logic first);
        if (sender_gaps && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_range_mm   <= rng;
        s_intensity  <= inten;
        s_scan_start <= first;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // invalid samples give no word, so let the pipe settle after the last point
    task wait_points_drained;
        s_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task set_angles(input int first_beam, input int angle_step);
        wait_points_drained();
        write_register(REG_FIRST_BEAM, CFG_DAT_W'(first_beam));
        write_register(REG_ANGLE_STEP, CFG_DAT_W'(angle_step));
        write_register(CFG_IDX_W'($urandom_range(int'(REG_ANGLE_STEP) + 1, int'(REG_NONE))),
                       CFG_DAT_W'($urandom()));
    endtask

    task test_directed_samples;
        // reset angles: start 0, step 1000
        send_sample(17'sd1, 16'h0000, 1'b1);
        send_sample(17'sd65535, 16'hFFFF, 1'b0);
        send_sample(17'sd0, 16'h1234, 1'b0);     // no point, index still moves
        send_sample(-17'sd1, 16'h5678, 1'b0);
        send_sample(RANGE_W'(-65536), 16'h9ABC, 1'b0);
        send_sample(17'sd2, 16'hDEF0, 1'b0);
        // every quadrant boundary, then a full turn back to zero
        set_angles(0, QUARTER_MDEG);
        for (int k = 0; k < 5; k++)
            send_sample(17'sd65535, INTEN_W'(k), k == 0);
        // negative start wraps to just below a full turn
        set_angles(-1, 45000);
        for (int k = 0; k < 4; k++)
            send_sample(17'sd65535, INTEN_W'($urandom()), k == 0);
        wait_points_drained();
        write_register(REG_NONE, '1);
    endtask

    // one long scan, mostly invalid samples, so the index climbs far
    task test_long_scan;
        logic signed [RANGE_W-1:0] rng;
        set_angles(-TURN_MDEG, TURN_MDEG - 1);
        for (int k = 0; k < LONG_SCAN_ITEMS; k++) begin
            if (k % 40 == 0 || k >= LONG_SCAN_ITEMS - 2)
                rng = RANGE_W'($urandom_range(1, 65535));
            else if (k % 3 == 0)
                rng = '0;
            else
                rng = RANGE_W'(-k);
            send_sample(rng, INTEN_W'($urandom()), k == 0);
        end
        // a new scan restarts from zero
        send_sample(17'sd30000, INTEN_W'($urandom()), 1'b1);
        send_sample(17'sd30000, INTEN_W'($urandom()), 1'b0);
    endtask

    task test_output_backpressure;
        wait_points_drained();
        sender_gaps  = 1'b0;
        hold_pending = 1'b1;
        for (int k = 0; k < 12; k++)
            send_sample(RANGE_W'($urandom_range(1, 65535)), INTEN_W'($urandom()), k == 0);
        sender_gaps = 1'b1;
        wait_points_drained();
    endtask

    task test_random_scans;
        int sent;
        int scan_len;
        logic signed [RANGE_W-1:0] rng;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_angles(0, 1000);
                1: set_angles(TURN_MDEG, 0);
                2: set_angles(-TURN_MDEG, TURN_MDEG);
                3: begin
                    set_angles(int'($urandom_range(0, 2 * TURN_MDEG)) - TURN_MDEG,
                               $urandom_range(0, TURN_MDEG));
                    sender_gaps = 1'b0;
                    sink_stalls = 1'b0;
                end
                4: set_angles(int'($urandom_range(0, 2 * TURN_MDEG)) - TURN_MDEG,
                              $urandom_range(1, 3000));
                default: set_angles(int'($urandom_range(0, 2 * TURN_MDEG)) - TURN_MDEG,
                                    TURN_MDEG - 1);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 24);
                for (int k = 0; k < scan_len && sent < PHASE_ITEMS; k++) begin
                    case ($urandom_range(0, 19))
                        0, 1:    rng = RANGE_W'($urandom());
                        2:       rng = '0;
                        3:       rng = 17'sd65535;
                        4:       rng = 17'sd1;
                        5:       rng = RANGE_W'($urandom_range(1, 16));
                        default: rng = RANGE_W'($urandom_range(1, 65535));
                    endcase
                    send_sample(rng, INTEN_W'($urandom()),
                                k == 0 || $urandom_range(0, 49) == 0);
                    sent++;
                end
            end
            sender_gaps = 1'b1;
            sink_stalls = 1'b1;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_samples();
        test_long_scan();
        test_output_backpressure();
        test_random_scans();
        wait_points_drained();
        if (mismatch_count == 0)
            $display("polar_scan_to_cartesian_test: PASS");
        else
            $display("polar_scan_to_cartesian_test: FAIL");
        $finish;
    end

endmodule
